// ===== rtl/slle_pkg.sv =====
// Shared types and codes for the static linked list engine.
// Used by the engine module in this folder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package slle_pkg;

  typedef enum logic [2:0] {
    CMD_ADD_FIRST = 3'd0,
    CMD_ADD_AFTER = 3'd1,
    CMD_ADD_LAST  = 3'd2,
    CMD_DEL_FIRST = 3'd3,
    CMD_DEL_AFTER = 3'd4,
    CMD_DEL_LAST  = 3'd5,
    CMD_DEL_ALL   = 3'd6,
    CMD_WALK      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_A,
    S_INS_B,
    S_TRAV,
    S_DEL_HEAD,
    S_DA_A,
    S_DA_B,
    S_WALK
  } state_t;

  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  position;
    logic [31:0] brand_word;
    logic [31:0] color_word;
    logic [31:0] size_word;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  element_count;
    logic [3:0]  slot;
    logic [31:0] out_brand;
    logic [31:0] out_color;
    logic [31:0] out_size;
    logic        last;
  } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/slle_mem.sv =====
// Simple dual-port synchronous memory with a registered read port.
// Holds the link words and the payload words; depends on no package.
`timescale 1ns / 1ps
`default_nettype none
module slle_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/slle_free_find.sv =====
// Registered lowest-free-slot finder over the slot used bits.
// Depends on no package.
`timescale 1ns / 1ps
`default_nettype none
module slle_free_find #(
  parameter int ENTRIES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [ENTRIES-1:0]         used,
  output logic      [$clog2(ENTRIES)-1:0] free_slot
);

  localparam int IW = $clog2(ENTRIES);

  logic [IW-1:0] free_next;

  always_comb begin
    free_next = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_next = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_slot <= '0;
    end else begin
      free_slot <= free_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/static_linked_list_engine.sv =====
// Static linked list engine: sequencer around the link and payload memories.
// Depends on slle_pkg, slle_mem and slle_free_find.
// The result strobe is registered. Words settled at the check (add_first, add_last to an empty
// list, full, empty, bad position, del_all) strobe from S_CHECK; del_first goes on to S_DEL_HEAD,
// add_after to S_INS_A and S_INS_B, del_after to S_DA_A (bad position at the tail) and S_DA_B,
// add_last hops the list in S_TRAV and then goes to S_INS_A and S_INS_B, del_last hops it in
// S_TRAV; walk strobes one word a cycle from S_WALK, at most 16 words. Busy drops with the final
// strobe, so the next word goes in after it. The receiver cannot stall, so nothing else waits.
// Reset is synchronous and empties the list; links and payload stay unwritten.
`timescale 1ns / 1ps
`default_nettype none
module static_linked_list_engine #(
  parameter int ENTRIES       = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire slle_pkg::in_word_t request,
  output logic                    valid,
  output slle_pkg::out_word_t     result
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = IW + 1;
  localparam int PW = PAYLOAD_WIDTH;

  slle_pkg::state_t    state, state_next;
  slle_pkg::in_word_t  req;
  slle_pkg::out_word_t result_next;
  logic                valid_next;
  logic [IW-1:0]       cur, cur_next, prev, prev_next, head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [3:0]          k, k_next;
  logic [ENTRIES-1:0]  used, used_next;
  logic [IW-1:0]       free_slot;

  logic          link_we;
  logic [IW-1:0] link_waddr, link_raddr;
  logic [LW-1:0] link_wdata, link_q;
  logic            pay_we;
  logic [IW-1:0]   pay_raddr;
  logic [3*PW-1:0] pay_q, pay_wdata;

  logic          full, empty, pos_ok, walk_fin;
  logic [IW-1:0] pidx;

  slle_mem #(.DEPTH(ENTRIES), .WIDTH(LW)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_q)
  );

  slle_mem #(.DEPTH(ENTRIES), .WIDTH(3 * PW)) u_pay (
    .clk(clk), .we(pay_we), .waddr(free_slot), .wdata(pay_wdata),
    .raddr(pay_raddr), .rdata(pay_q)
  );

  slle_free_find #(.ENTRIES(ENTRIES)) u_free (
    .clk(clk), .rst(rst), .used(used), .free_slot(free_slot)
  );

  assign busy      = (state != slle_pkg::S_IDLE);
  assign full      = (count == CW'(ENTRIES));
  assign empty     = (count == '0);
  assign pidx      = IW'(req.position);
  assign pos_ok    = (32'(req.position) < ENTRIES) && used[pidx];
  assign pay_wdata = {PW'(req.brand_word), PW'(req.color_word), PW'(req.size_word)};
  assign walk_fin  = link_q[IW] || ((32'(k) + 32'd1) >= 32'(count))
                     || ((32'(k) + 32'd1) == slle_pkg::MAX_RESULTS);

  always_comb begin
    state_next = state;
    case (state)
      slle_pkg::S_IDLE: begin
        if (start) state_next = slle_pkg::S_CHECK;
      end
      slle_pkg::S_CHECK: begin
        state_next = slle_pkg::S_IDLE;
        case (req.command)
          slle_pkg::CMD_ADD_FIRST, slle_pkg::CMD_ADD_LAST: begin
            if (!full && req.command == slle_pkg::CMD_ADD_LAST && !empty) begin
              state_next = slle_pkg::S_TRAV;
            end
          end
          slle_pkg::CMD_ADD_AFTER: begin
            if (!full && pos_ok) state_next = slle_pkg::S_INS_A;
          end
          slle_pkg::CMD_DEL_FIRST, slle_pkg::CMD_DEL_LAST: begin
            if (!empty) begin
              if (req.command == slle_pkg::CMD_DEL_FIRST || count == CW'(1)) begin
                state_next = slle_pkg::S_DEL_HEAD;
              end else begin
                state_next = slle_pkg::S_TRAV;
              end
            end
          end
          slle_pkg::CMD_DEL_AFTER: begin
            if (!empty && pos_ok) state_next = slle_pkg::S_DA_A;
          end
          slle_pkg::CMD_WALK: begin
            if (!empty) state_next = slle_pkg::S_WALK;
          end
          default: state_next = slle_pkg::S_IDLE;
        endcase
      end
      slle_pkg::S_INS_A: state_next = slle_pkg::S_INS_B;
      slle_pkg::S_TRAV: begin
        if (link_q[IW]) begin
          state_next = (req.command == slle_pkg::CMD_ADD_LAST) ? slle_pkg::S_INS_A
                                                               : slle_pkg::S_IDLE;
        end
      end
      slle_pkg::S_DA_A: begin
        state_next = link_q[IW] ? slle_pkg::S_IDLE : slle_pkg::S_DA_B;
      end
      slle_pkg::S_WALK: begin
        if (walk_fin) state_next = slle_pkg::S_IDLE;
      end
      default: state_next = slle_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cur_next    = cur;
    prev_next   = prev;
    head_next   = head;
    count_next  = count;
    k_next      = k;
    used_next   = used;
    valid_next  = 1'b0;
    result_next = '0;
    link_we     = 1'b0;
    link_waddr  = free_slot;
    link_wdata  = link_q;
    link_raddr  = cur;
    pay_we      = 1'b0;
    pay_raddr   = cur;
    result_next.status = slle_pkg::ST_OK;
    result_next.last   = 1'b1;
    case (state)
      slle_pkg::S_CHECK: begin
        valid_next = 1'b1;
        case (req.command)
          slle_pkg::CMD_ADD_FIRST, slle_pkg::CMD_ADD_LAST, slle_pkg::CMD_ADD_AFTER: begin
            if (full) begin
              result_next.status = slle_pkg::ST_FULL;
            end else if (req.command == slle_pkg::CMD_ADD_AFTER) begin
              if (!pos_ok) begin
                result_next.status = slle_pkg::ST_BADPOS;
              end else begin
                valid_next = 1'b0;
                cur_next   = pidx;
                link_raddr = pidx;
              end
            end else if (req.command == slle_pkg::CMD_ADD_FIRST || empty) begin
              link_we    = 1'b1;
              link_wdata = empty ? {1'b1, IW'(0)} : {1'b0, head};
              pay_we     = 1'b1;
              used_next[free_slot] = 1'b1;
              count_next = count + CW'(1);
              head_next  = free_slot;
              result_next.slot = 4'(free_slot);
            end else begin
              valid_next = 1'b0;
              cur_next   = head;
              prev_next  = head;
              link_raddr = head;
            end
          end
          slle_pkg::CMD_DEL_FIRST, slle_pkg::CMD_DEL_LAST: begin
            if (empty) begin
              result_next.status = slle_pkg::ST_EMPTY;
            end else begin
              valid_next = 1'b0;
              cur_next   = head;
              prev_next  = head;
              link_raddr = head;
            end
          end
          slle_pkg::CMD_DEL_AFTER: begin
            if (empty) begin
              result_next.status = slle_pkg::ST_EMPTY;
            end else if (!pos_ok) begin
              result_next.status = slle_pkg::ST_BADPOS;
            end else begin
              valid_next = 1'b0;
              cur_next   = pidx;
              link_raddr = pidx;
            end
          end
          slle_pkg::CMD_DEL_ALL: begin
            used_next  = '0;
            count_next = '0;
          end
          slle_pkg::CMD_WALK: begin
            if (empty) begin
              result_next.status = slle_pkg::ST_EMPTY;
            end else begin
              valid_next = 1'b0;
              cur_next   = head;
              k_next     = '0;
              link_raddr = head;
              pay_raddr  = head;
            end
          end
          default: valid_next = 1'b0;
        endcase
      end
      slle_pkg::S_INS_A: begin
        link_we    = 1'b1;
        link_waddr = free_slot;
        link_wdata = link_q;
      end
      slle_pkg::S_INS_B: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = {1'b0, free_slot};
        pay_we     = 1'b1;
        used_next[free_slot] = 1'b1;
        count_next = count + CW'(1);
        valid_next = 1'b1;
        result_next.slot = 4'(free_slot);
      end
      slle_pkg::S_TRAV: begin
        if (link_q[IW]) begin
          if (req.command != slle_pkg::CMD_ADD_LAST) begin
            link_we    = 1'b1;
            link_waddr = prev;
            link_wdata = link_q;
            used_next[cur] = 1'b0;
            count_next = count - CW'(1);
            valid_next = 1'b1;
          end
        end else begin
          prev_next  = cur;
          cur_next   = link_q[IW-1:0];
          link_raddr = link_q[IW-1:0];
        end
      end
      slle_pkg::S_DEL_HEAD: begin
        if (count > CW'(1)) head_next = link_q[IW-1:0];
        used_next[cur] = 1'b0;
        count_next = count - CW'(1);
        valid_next = 1'b1;
      end
      slle_pkg::S_DA_A: begin
        if (link_q[IW]) begin
          valid_next = 1'b1;
          result_next.status = slle_pkg::ST_BADPOS;
        end else begin
          prev_next  = link_q[IW-1:0];
          link_raddr = link_q[IW-1:0];
        end
      end
      slle_pkg::S_DA_B: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = link_q;
        used_next[prev] = 1'b0;
        count_next = count - CW'(1);
        valid_next = 1'b1;
      end
      slle_pkg::S_WALK: begin
        valid_next = 1'b1;
        result_next.slot      = 4'(cur);
        result_next.out_brand = 32'(pay_q[3*PW-1 -: PW]);
        result_next.out_color = 32'(pay_q[2*PW-1 -: PW]);
        result_next.out_size  = 32'(pay_q[PW-1:0]);
        result_next.last      = walk_fin;
        if (!walk_fin) begin
          cur_next   = link_q[IW-1:0];
          k_next     = k + 4'd1;
          link_raddr = link_q[IW-1:0];
          pay_raddr  = link_q[IW-1:0];
        end
      end
      default: begin
      end
    endcase
    result_next.element_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slle_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      used  <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      used  <= used_next;
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req <= request;
    cur    <= cur_next;
    prev   <= prev_next;
    k      <= k_next;
    result <= result_next;
  end

endmodule
`default_nettype wire

// ===== test/static_linked_list_engine_test.sv =====
// Self-checking testbench for static_linked_list_engine: directed and random command words,
// a predictor of the slot store and the list, and a checker of every result word.
// Depends on slle_pkg and the engine RTL.
`timescale 1ns / 1ps
module static_linked_list_engine_test;
  import slle_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    in_word_t word;
    bit       drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  request = '0;
  logic      valid;
  out_word_t result;

  pending_t  pending_words[$];
  out_word_t expected_words[$];

  bit          slot_used [SLOTS];
  logic [3:0]  slot_link [SLOTS];
  bit          slot_tail [SLOTS];
  logic [95:0] slot_payload [SLOTS];
  logic [3:0]  head;
  int          count;

  int issued = 0;
  int accepted = 0;
  int checked = 0;
  int walk_words = 0;
  int failures = 0;
  int cycles = 0;

  static_linked_list_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .valid(valid), .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void push_result(status_t st, logic [3:0] s, bit with_pay, bit fin);
    out_word_t e;
    e = '0;
    e.status = st;
    e.element_count = count[4:0];
    e.slot = s;
    if (with_pay) begin
      e.out_brand = slot_payload[s][95:64];
      e.out_color = slot_payload[s][63:32];
      e.out_size = slot_payload[s][31:0];
    end
    e.last = fin;
    expected_words.push_back(e);
  endfunction

  function automatic logic [3:0] lowest_free();
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i]) return 4'(i);
    end
    return 4'd0;
  endfunction

  function automatic void occupy(logic [3:0] s, in_word_t w);
    slot_payload[s] = {w.brand_word, w.color_word, w.size_word};
    slot_used[s] = 1'b1;
    count++;
  endfunction

  function automatic logic [3:0] link_first(in_word_t w);
    logic [3:0] s;
    s = lowest_free();
    slot_tail[s] = (count == 0);
    slot_link[s] = (count == 0) ? 4'd0 : head;
    occupy(s, w);
    head = s;
    return s;
  endfunction

  function automatic logic [3:0] link_after(logic [3:0] p, in_word_t w);
    logic [3:0] s;
    s = lowest_free();
    slot_link[s] = slot_link[p];
    slot_tail[s] = slot_tail[p];
    slot_link[p] = s;
    slot_tail[p] = 1'b0;
    occupy(s, w);
    return s;
  endfunction

  function automatic logic [3:0] find_tail(output logic [3:0] prev);
    logic [3:0] cur;
    cur = head;
    prev = cur;
    for (int n = 0; n < SLOTS && !slot_tail[cur]; n++) begin
      prev = cur;
      cur = slot_link[cur];
    end
    return cur;
  endfunction

  function automatic void unlink_after(logic [3:0] p);
    logic [3:0] d;
    d = slot_link[p];
    slot_link[p] = slot_link[d];
    slot_tail[p] = slot_tail[d];
    slot_used[d] = 1'b0;
    count--;
  endfunction

  // Applies one accepted command word to the list copy and queues its result words.
  function automatic void apply_command(in_word_t w);
    logic [3:0] s;
    logic [3:0] prev;
    logic [3:0] t;
    bit fin;
    case (w.command)
      CMD_ADD_FIRST, CMD_ADD_LAST: begin
        if (count >= SLOTS) push_result(ST_FULL, 4'd0, 0, 1);
        else begin
          if (w.command == CMD_ADD_FIRST || count == 0) s = link_first(w);
          else begin
            t = find_tail(prev);
            s = link_after(t, w);
          end
          push_result(ST_OK, s, 0, 1);
        end
      end
      CMD_ADD_AFTER: begin
        if (count >= SLOTS) push_result(ST_FULL, 4'd0, 0, 1);
        else if (!slot_used[w.position]) push_result(ST_BADPOS, 4'd0, 0, 1);
        else begin
          s = link_after(w.position, w);
          push_result(ST_OK, s, 0, 1);
        end
      end
      CMD_DEL_FIRST, CMD_DEL_LAST: begin
        if (count == 0) push_result(ST_EMPTY, 4'd0, 0, 1);
        else begin
          if (w.command == CMD_DEL_FIRST || count == 1) begin
            s = head;
            if (count > 1) head = slot_link[s];
            slot_used[s] = 1'b0;
            count--;
          end else begin
            t = find_tail(prev);
            unlink_after(prev);
          end
          push_result(ST_OK, 4'd0, 0, 1);
        end
      end
      CMD_DEL_AFTER: begin
        if (count == 0) push_result(ST_EMPTY, 4'd0, 0, 1);
        else if (!slot_used[w.position] || slot_tail[w.position])
          push_result(ST_BADPOS, 4'd0, 0, 1);
        else begin
          unlink_after(w.position);
          push_result(ST_OK, 4'd0, 0, 1);
        end
      end
      CMD_DEL_ALL: begin
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        count = 0;
        push_result(ST_OK, 4'd0, 0, 1);
      end
      default: begin
        if (count == 0) push_result(ST_EMPTY, 4'd0, 0, 1);
        else begin
          s = head;
          for (int k = 0; k < MAX_RESULTS; k++) begin
            fin = slot_tail[s] || (k + 1 >= count) || (k + 1 == MAX_RESULTS);
            push_result(ST_OK, s, 1, fin);
            if (fin) break;
            s = slot_link[s];
          end
        end
      end
    endcase
  endfunction

  function automatic void add_word(cmd_t c, logic [3:0] p, bit drain = 0);
    pending_t e;
    e.word.command = c;
    e.word.position = p;
    e.word.brand_word = $urandom;
    e.word.color_word = $urandom;
    e.word.size_word = $urandom;
    e.drain = drain;
    pending_words.push_back(e);
  endfunction

  always @(posedge clk) begin
    bit took;
    bit idle;
    took = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        apply_command(request);
        accepted++;
      end
      if (!start || took) begin
        idle = !(issued >= 100 && issued < 170) && $urandom_range(99) < 9;
        if (pending_words.size() != 0 && !idle &&
            !(pending_words[0].drain && (expected_words.size() != 0 || took))) begin
          request <= pending_words[0].word;
          void'(pending_words.pop_front());
          start <= 1'b1;
          issued++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (!rst && valid) begin
      if (result.last && result.status == ST_OK && result.out_brand | result.out_color |
          result.out_size) walk_words++;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Unexpected result word: %p", result);
      end else begin
        e = expected_words.pop_front();
        checked++;
        if (result.status !== e.status || result.element_count !== e.element_count ||
            result.slot !== e.slot || result.out_brand !== e.out_brand ||
            result.out_color !== e.out_color || result.out_size !== e.out_size ||
            result.last !== e.last) begin
          failures++;
          if (failures <= 10) $display("Mismatch: expected %p, got %p", e, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("static_linked_list_engine_test failed");
      $finish;
    end
  end

  initial begin
    int mode;
    int r;
    // Empty list cases, then payload extremes, positions at free slots and at the tail.
    add_word(CMD_WALK, 4'd0);
    add_word(CMD_DEL_FIRST, 4'd0);
    add_word(CMD_DEL_AFTER, 4'd3);
    add_word(CMD_DEL_LAST, 4'd0);
    add_word(CMD_ADD_AFTER, 4'd0);
    add_word(CMD_ADD_LAST, 4'd0);
    pending_words[$].word.brand_word = '1;
    pending_words[$].word.color_word = '1;
    pending_words[$].word.size_word = '1;
    add_word(CMD_ADD_FIRST, 4'd0);
    pending_words[$].word.brand_word = '0;
    pending_words[$].word.color_word = '0;
    pending_words[$].word.size_word = '0;
    add_word(CMD_ADD_AFTER, 4'd1);
    add_word(CMD_ADD_AFTER, 4'd15);
    add_word(CMD_DEL_AFTER, 4'd15);
    add_word(CMD_DEL_AFTER, 4'd0);
    add_word(CMD_ADD_LAST, 4'd0);
    add_word(CMD_WALK, 4'd0);
    add_word(CMD_DEL_AFTER, 4'd1);
    add_word(CMD_DEL_LAST, 4'd0);
    add_word(CMD_DEL_FIRST, 4'd0);
    add_word(CMD_WALK, 4'd0);
    add_word(CMD_DEL_ALL, 4'd0);
    add_word(CMD_WALK, 4'd0);
    add_word(CMD_ADD_LAST, 4'd0, 1);
    add_word(CMD_DEL_LAST, 4'd0);
    // Growth phases fill the store; shrink phases empty it again.
    for (int i = 0; i < 260; i++) begin
      mode = (i / 40) % 2;
      r = $urandom_range(99);
      if (i % 25 == 24) add_word(CMD_WALK, 4'($urandom_range(15)));
      else if (i == 130) add_word(CMD_WALK, 4'd0, 1);
      else if (r < 2) add_word(CMD_DEL_ALL, 4'd0);
      else if (mode == 0 ? r < 80 : r < 25)
        add_word(cmd_t'(3'($urandom_range(2))), 4'($urandom_range(15)));
      else if (r < 92) add_word(cmd_t'(3'($urandom_range(5, 3))), 4'($urandom_range(15)));
      else add_word(CMD_WALK, 4'd0);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d command words and checked %0d result words, with full, empty,",
             accepted, checked);
    $display("bad position and walk cases across growth and shrink phases.");
    if (failures == 0 && expected_words.size() == 0) begin
      $display("static_linked_list_engine_test passed");
    end else begin
      $display("%0d failures", failures);
      $display("static_linked_list_engine_test failed");
    end
    $finish;
  end

endmodule
